// File: rtl/core/pir_pkg.sv
// Shared types, constants and helpers for the particle integrator.
`timescale 1ns / 1ps
package pir_pkg;

  localparam int WORD_W             = 32;
  localparam int DIMENSIONS_DEF     = 3;
  localparam int FRACTION_BITS_DEF  = 16;
  localparam int MAX_LANES          = 3;
  localparam int CFG_IDX_W          = 3;
  localparam int WIDE_W             = 66;

  localparam logic [WORD_W-1:0] STEP_DT_RST   = 32'd655;
  localparam logic [WORD_W-1:0] BOX_MIN_RST   = 32'd0;
  localparam logic [WORD_W-1:0] BOX_MAX_RST   = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_DT   = 3'd0,
    REG_BOX_MIN_X = 3'd1,
    REG_BOX_MIN_Y = 3'd2,
    REG_BOX_MIN_Z = 3'd3,
    REG_BOX_MAX_X = 3'd4,
    REG_BOX_MAX_Y = 3'd5,
    REG_BOX_MAX_Z = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
    logic signed [WORD_W-1:0] vel_x;
    logic signed [WORD_W-1:0] vel_y;
    logic signed [WORD_W-1:0] vel_z;
    logic signed [WORD_W-1:0] force_x;
    logic signed [WORD_W-1:0] force_y;
    logic signed [WORD_W-1:0] force_z;
    logic        [WORD_W-1:0] mass;
  } pir_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] new_pos_x;
    logic signed [WORD_W-1:0] new_pos_y;
    logic signed [WORD_W-1:0] new_pos_z;
    logic signed [WORD_W-1:0] new_vel_x;
    logic signed [WORD_W-1:0] new_vel_y;
    logic signed [WORD_W-1:0] new_vel_z;
    logic                     saturated;
  } pir_out_t;

  // Result of one axis lane toward the merge stage.
  typedef struct packed {
    logic                     valid;
    logic                     sat;
    logic signed [WORD_W-1:0] pos;
    logic signed [WORD_W-1:0] vel;
  } lane_res_t;

  localparam logic signed [WIDE_W-1:0] MAX_WIDE = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] MIN_WIDE = -66'sd2147483648;

  // Clamp to a signed word; top bit of the result flags a clamp.
  function automatic logic [WORD_W:0] clamp_word(input logic signed [WIDE_W-1:0] v);
    logic [WORD_W:0] r;
    if (v > MAX_WIDE) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < MIN_WIDE) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[WORD_W-1:0]};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/pir_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
`timescale 1ns / 1ps
module pir_div #(
  parameter int FRACTION_BITS = pir_pkg::FRACTION_BITS_DEF,
  parameter int SIDE_W        = 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic [pir_pkg::WORD_W-1:0]             in_mag,
  input  logic [pir_pkg::WORD_W-1:0]             in_div,
  input  logic [SIDE_W-1:0]                      in_side,
  output logic                                   out_valid,
  output logic [pir_pkg::WORD_W+FRACTION_BITS-1:0] out_quo,
  output logic [SIDE_W-1:0]                      out_side
);
  import pir_pkg::*;

  localparam int QW = WORD_W + FRACTION_BITS;

  logic              vld  [QW+1];
  logic [WORD_W-1:0] rem  [QW+1];
  logic [QW-1:0]     quo  [QW+1];
  logic [QW-1:0]     dvd  [QW+1];
  logic [WORD_W-1:0] dvs  [QW+1];
  logic [SIDE_W-1:0] side [QW+1];

  logic [WORD_W:0]   trial    [QW];
  logic              ge       [QW];
  logic [WORD_W-1:0] rem_next [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial[k]    = {rem[k], dvd[k][QW-1]};
      ge[k]       = trial[k] >= {1'b0, dvs[k]};
      rem_next[k] = ge[k] ? WORD_W'(trial[k] - {1'b0, dvs[k]}) : trial[k][WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) vld[k] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int k = 1; k <= QW; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    rem[0]  <= '0;
    quo[0]  <= '0;
    dvd[0]  <= {in_mag, {FRACTION_BITS{1'b0}}};
    dvs[0]  <= in_div;
    side[0] <= in_side;
    for (int k = 1; k <= QW; k++) begin
      rem[k]  <= rem_next[k-1];
      quo[k]  <= {quo[k-1][QW-2:0], ge[k-1]};
      dvd[k]  <= {dvd[k-1][QW-2:0], 1'b0};
      dvs[k]  <= dvs[k-1];
      side[k] <= side[k-1];
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_side  = side[QW];

endmodule

// File: rtl/core/pir_lane.sv
// One axis lane: divide, two multiply-accumulates and two wall reflections.
`timescale 1ns / 1ps
module pir_lane #(
  parameter int FRACTION_BITS = pir_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [pir_pkg::WORD_W-1:0] pos,
  input  logic signed [pir_pkg::WORD_W-1:0] vel,
  input  logic signed [pir_pkg::WORD_W-1:0] frc,
  input  logic        [pir_pkg::WORD_W-1:0] mass,
  input  logic        [pir_pkg::WORD_W-1:0] step_dt,
  input  logic signed [pir_pkg::WORD_W-1:0] wall_min,
  input  logic signed [pir_pkg::WORD_W-1:0] wall_max,
  output pir_pkg::lane_res_t                res
);
  import pir_pkg::*;

  localparam int QW     = WORD_W + FRACTION_BITS;
  localparam int SIDE_W = 2 + 2 * WORD_W;
  localparam int PROD_W = 2 * WORD_W;

  localparam logic [QW-1:0] POS_LIMIT = QW'(33'h0_7FFF_FFFF);
  localparam logic [QW-1:0] NEG_LIMIT = QW'(33'h0_8000_0000);

  logic [WORD_W-1:0] frc_mag;
  logic              q_valid;
  logic [QW-1:0]     q;
  logic [SIDE_W-1:0] q_side;
  logic              q_sign, q_zero;
  logic [WORD_W-1:0] q_pos, q_vel;

  assign frc_mag = frc[WORD_W-1] ? WORD_W'(-frc) : frc;

  pir_div #(.FRACTION_BITS(FRACTION_BITS), .SIDE_W(SIDE_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mag    (frc_mag),
    .in_div    (mass),
    .in_side   ({frc[WORD_W-1], frc == '0, pos, vel}),
    .out_valid (q_valid),
    .out_quo   (q),
    .out_side  (q_side)
  );

  assign {q_sign, q_zero, q_pos, q_vel} = q_side;

  // Stage valids.
  logic a_v, b_v, c_v, d_v, e_v, f_v, g_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      {a_v, b_v, c_v, d_v, e_v, f_v, g_v} <= '0;
    end else begin
      a_v <= q_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v;
      f_v <= e_v;
      g_v <= f_v;
    end
  end

  // Acceleration clamp.
  logic              a_sign, a_sat;
  logic [WORD_W-1:0] a_mag;
  logic signed [WORD_W-1:0] a_pos, a_vel;
  logic              a_sat_next;
  logic [WORD_W-1:0] a_mag_next;

  always_comb begin
    a_sat_next = 1'b0;
    a_mag_next = q[WORD_W-1:0];
    if (q_zero) begin
      a_mag_next = '0;
    end else if (!q_sign && q > POS_LIMIT) begin
      a_mag_next = POS_LIMIT[WORD_W-1:0];
      a_sat_next = 1'b1;
    end else if (q_sign && q > NEG_LIMIT) begin
      a_mag_next = NEG_LIMIT[WORD_W-1:0];
      a_sat_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    a_sign <= q_sign;
    a_sat  <= a_sat_next;
    a_mag  <= a_mag_next;
    a_pos  <= q_pos;
    a_vel  <= q_vel;
  end

  // Velocity step product.
  logic              b_sign, b_sat;
  logic [PROD_W-1:0] b_prod;
  logic signed [WORD_W-1:0] b_pos, b_vel;

  always_ff @(posedge clk) begin
    b_sign <= a_sign;
    b_sat  <= a_sat;
    b_prod <= a_mag * step_dt;
    b_pos  <= a_pos;
    b_vel  <= a_vel;
  end

  // Velocity update.
  logic                     c_sat;
  logic signed [WORD_W-1:0] c_pos, c_vel;
  logic [PROD_W-1:0]        dv_mag;
  logic signed [WIDE_W-1:0] dv, vsum;
  logic [WORD_W:0]          vclamp;

  always_comb begin
    dv_mag = b_prod >> FRACTION_BITS;
    dv     = $signed({2'b00, dv_mag});
    if (b_sign) dv = -dv;
    vsum   = WIDE_W'(b_vel) + dv;
    vclamp = clamp_word(vsum);
  end

  always_ff @(posedge clk) begin
    c_sat <= b_sat | vclamp[WORD_W];
    c_vel <= vclamp[WORD_W-1:0];
    c_pos <= b_pos;
  end

  // Position step product.
  logic                     d_sign, d_sat;
  logic [PROD_W-1:0]        d_prod;
  logic signed [WORD_W-1:0] d_pos, d_vel;
  logic [WORD_W-1:0]        vmag;

  assign vmag = c_vel[WORD_W-1] ? WORD_W'(-c_vel) : c_vel;

  always_ff @(posedge clk) begin
    d_sign <= c_vel[WORD_W-1];
    d_sat  <= c_sat;
    d_prod <= vmag * step_dt;
    d_pos  <= c_pos;
    d_vel  <= c_vel;
  end

  // Position update.
  logic                     e_sat;
  logic signed [WORD_W-1:0] e_pos, e_vel;
  logic [PROD_W-1:0]        dp_mag;
  logic signed [WIDE_W-1:0] dp, psum;
  logic [WORD_W:0]          pclamp;

  always_comb begin
    dp_mag = d_prod >> FRACTION_BITS;
    dp     = $signed({2'b00, dp_mag});
    if (d_sign) dp = -dp;
    psum   = WIDE_W'(d_pos) + dp;
    pclamp = clamp_word(psum);
  end

  always_ff @(posedge clk) begin
    e_sat <= d_sat | pclamp[WORD_W];
    e_pos <= pclamp[WORD_W-1:0];
    e_vel <= d_vel;
  end

  // Lower wall.
  logic                     f_sat;
  logic signed [WORD_W-1:0] f_pos, f_vel;
  logic [WORD_W:0]          lo_pos, lo_vel;

  always_comb begin
    lo_pos = clamp_word((WIDE_W'(wall_min) <<< 1) - WIDE_W'(e_pos));
    lo_vel = clamp_word(-WIDE_W'(e_vel));
  end

  always_ff @(posedge clk) begin
    if (e_pos < wall_min) begin
      f_pos <= lo_pos[WORD_W-1:0];
      f_vel <= lo_vel[WORD_W-1:0];
      f_sat <= e_sat | lo_pos[WORD_W] | lo_vel[WORD_W];
    end else begin
      f_pos <= e_pos;
      f_vel <= e_vel;
      f_sat <= e_sat;
    end
  end

  // Upper wall.
  logic                     g_sat;
  logic signed [WORD_W-1:0] g_pos, g_vel;
  logic [WORD_W:0]          hi_pos, hi_vel;

  always_comb begin
    hi_pos = clamp_word((WIDE_W'(wall_max) <<< 1) - WIDE_W'(f_pos));
    hi_vel = clamp_word(-WIDE_W'(f_vel));
  end

  always_ff @(posedge clk) begin
    if (f_pos > wall_max) begin
      g_pos <= hi_pos[WORD_W-1:0];
      g_vel <= hi_vel[WORD_W-1:0];
      g_sat <= f_sat | hi_pos[WORD_W] | hi_vel[WORD_W];
    end else begin
      g_pos <= f_pos;
      g_vel <= f_vel;
      g_sat <= f_sat;
    end
  end

  assign res = '{valid: g_v, sat: g_sat, pos: g_pos, vel: g_vel};

endmodule

// File: rtl/core/particle_integrate_reflect.sv
// Top level: config registers, axis lanes and the merge/output stage.
`timescale 1ns / 1ps
// Particle integrator with reflecting box walls.
// Input channel: drive in_data and raise start; the word is taken at any rising
// edge where start is high and busy is low. busy stays low, so one particle
// can enter on every cycle.
// Result channel: done pulses for one cycle with out_data valid in that cycle.
// There is no backpressure; capture the word when done is high.
// Path from acceptance to done: the bit-per-stage force/mass divider in
// each lane, then seven arithmetic stages and the merge register.
// Throughput: one particle per cycle, results in input order.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Index 0 is the time step, 1..3 the lower walls, 4..6 the
// upper walls; other indexes are dropped. Write only while the pipeline is
// empty.
// Reset (synchronous, active high) flushes all items in flight and restores
// dt = 655, lower walls 0, upper walls 1.0.
// In two-dimensional builds the z outputs read zero.
module particle_integrate_reflect #(
  parameter int DIMENSIONS    = pir_pkg::DIMENSIONS_DEF,
  parameter int FRACTION_BITS = pir_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  pir_pkg::pir_in_t                 in_data,
  output logic                             done,
  output pir_pkg::pir_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pir_pkg::WORD_W-1:0]       cfg_data
);
  import pir_pkg::*;

  localparam int LATENCY = WORD_W + FRACTION_BITS + 9;

  // Configuration registers.
  logic        [WORD_W-1:0] step_dt;
  logic signed [WORD_W-1:0] box_min [MAX_LANES];
  logic signed [WORD_W-1:0] box_max [MAX_LANES];

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_dt <= STEP_DT_RST;
      for (int l = 0; l < MAX_LANES; l++) begin
        box_min[l] <= BOX_MIN_RST;
        box_max[l] <= BOX_MAX_RST;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_DT:   step_dt    <= cfg_data;
        REG_BOX_MIN_X: box_min[0] <= cfg_data;
        REG_BOX_MIN_Y: box_min[1] <= cfg_data;
        REG_BOX_MIN_Z: box_min[2] <= cfg_data;
        REG_BOX_MAX_X: box_max[0] <= cfg_data;
        REG_BOX_MAX_Y: box_max[1] <= cfg_data;
        REG_BOX_MAX_Z: box_max[2] <= cfg_data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Fan the particle word out per axis.
  logic signed [WORD_W-1:0] lane_pos [MAX_LANES];
  logic signed [WORD_W-1:0] lane_vel [MAX_LANES];
  logic signed [WORD_W-1:0] lane_frc [MAX_LANES];
  lane_res_t                lane_out [MAX_LANES];
  logic                     accept;

  assign accept = start && !busy;

  always_comb begin
    lane_pos[0] = in_data.pos_x;   lane_vel[0] = in_data.vel_x;
    lane_frc[0] = in_data.force_x;
    lane_pos[1] = in_data.pos_y;   lane_vel[1] = in_data.vel_y;
    lane_frc[1] = in_data.force_y;
    lane_pos[2] = in_data.pos_z;   lane_vel[2] = in_data.vel_z;
    lane_frc[2] = in_data.force_z;
  end

  for (genvar l = 0; l < MAX_LANES; l++) begin : g_lane
    if (l < DIMENSIONS) begin : g_on
      pir_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (accept),
        .pos       (lane_pos[l]),
        .vel       (lane_vel[l]),
        .frc       (lane_frc[l]),
        .mass      (in_data.mass),
        .step_dt   (step_dt),
        .wall_min  (box_min[l]),
        .wall_max  (box_max[l]),
        .res       (lane_out[l])
      );
    end else begin : g_off
      // Unused axis: hold zero position and velocity, never saturates.
      assign lane_out[l] = '0;
    end
  end

  // Merge: all lanes run in lockstep, so lane 0 carries the valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lane_out[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data.new_pos_x <= lane_out[0].pos;
    out_data.new_pos_y <= lane_out[1].pos;
    out_data.new_pos_z <= lane_out[2].pos;
    out_data.new_vel_x <= lane_out[0].vel;
    out_data.new_vel_y <= lane_out[1].vel;
    out_data.new_vel_z <= lane_out[2].vel;
    out_data.saturated <= lane_out[0].sat | lane_out[1].sat | lane_out[2].sat;
  end

`ifndef SYNTHESIS
  // Every result traces back to an accepted input word.
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching input word");

  // An accepted word always yields a result after the fixed latency.
  a_start_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY (done || $past(rst, LATENCY - 1)))
    else $error("accepted word produced no result");

  // In a planar build the z result must stay zero.
  a_planar_z: assert property (@(posedge clk) disable iff (rst)
    done |-> (DIMENSIONS == 3 ||
              (out_data.new_pos_z == '0 && out_data.new_vel_z == '0)))
    else $error("z output nonzero in planar build");
`endif

endmodule

// File: dv/pir_checker.sv
// Checker for the particle integrator: mirrors the registers, predicts and compares results.
`timescale 1ns / 1ps
module pir_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  pir_pkg::pir_in_t              in_data,
  input  logic                          done,
  input  pir_pkg::pir_out_t             out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pir_pkg::WORD_W-1:0]    cfg_data,
  output int                            fails,
  output int                            pending
);
  import pir_pkg::*;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  longint unsigned step_dt;
  longint          wall_lo[3];
  longint          wall_hi[3];
  pir_out_t        expected_words[$];

  function automatic longint clamp_to_word(longint v, inout bit sat);
    if (v > WORD_MAX) begin
      sat = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      sat = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  // (a * b) >> F, rounded toward zero
  function automatic longint scale_by_dt(longint a, longint unsigned b);
    longint unsigned mag;
    longint unsigned p;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    p = (mag * b) >> FRACTION_BITS_DEF;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint accel_of(longint f, longint unsigned m, inout bit sat);
    longint unsigned mag;
    longint unsigned q;
    mag = (f < 0) ? longint'(-f) : longint'(f);
    if (m == 0) begin
      if (mag == 0) return 0;
      sat = 1'b1;
      return (f < 0) ? WORD_MIN : WORD_MAX;
    end
    q = (mag << FRACTION_BITS_DEF) / m;
    return clamp_to_word((f < 0) ? -longint'(q) : longint'(q), sat);
  endfunction

  function automatic pir_out_t integrate(pir_in_t w);
    pir_out_t r;
    bit       sat;
    longint   pos[3];
    longint   vel[3];
    longint   frc[3];
    longint   acc;
    sat = 1'b0;
    pos = '{longint'(w.pos_x), longint'(w.pos_y), longint'(w.pos_z)};
    vel = '{longint'(w.vel_x), longint'(w.vel_y), longint'(w.vel_z)};
    frc = '{longint'(w.force_x), longint'(w.force_y), longint'(w.force_z)};
    for (int d = 0; d < 3; d++) begin
      if (d < DIMENSIONS_DEF) begin
        acc = accel_of(frc[d], longint'(w.mass), sat);
        vel[d] = clamp_to_word(vel[d] + scale_by_dt(acc, step_dt), sat);
        pos[d] = clamp_to_word(pos[d] + scale_by_dt(vel[d], step_dt), sat);
        if (pos[d] < wall_lo[d]) begin
          pos[d] = clamp_to_word(2 * wall_lo[d] - pos[d], sat);
          vel[d] = clamp_to_word(-vel[d], sat);
        end
        if (pos[d] > wall_hi[d]) begin
          pos[d] = clamp_to_word(2 * wall_hi[d] - pos[d], sat);
          vel[d] = clamp_to_word(-vel[d], sat);
        end
      end else begin
        pos[d] = 0;
        vel[d] = 0;
      end
    end
    r.new_pos_x = pos[0][31:0];
    r.new_pos_y = pos[1][31:0];
    r.new_pos_z = pos[2][31:0];
    r.new_vel_x = vel[0][31:0];
    r.new_vel_y = vel[1][31:0];
    r.new_vel_z = vel[2][31:0];
    r.saturated = sat;
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  assign pending = expected_words.size();

  always @(posedge clk) begin
    pir_out_t e;
    if (rst) begin
      step_dt = STEP_DT_RST;
      for (int d = 0; d < 3; d++) begin
        wall_lo[d] = longint'($signed(BOX_MIN_RST));
        wall_hi[d] = longint'($signed(BOX_MAX_RST));
      end
      expected_words.delete();
      fails = 0;
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected result word %h", $time, out_data);
          fails++;
        end else begin
          e = expected_words.pop_front();
          compare_field("new_pos_x", e.new_pos_x, out_data.new_pos_x);
          compare_field("new_pos_y", e.new_pos_y, out_data.new_pos_y);
          compare_field("new_pos_z", e.new_pos_z, out_data.new_pos_z);
          compare_field("new_vel_x", e.new_vel_x, out_data.new_vel_x);
          compare_field("new_vel_y", e.new_vel_y, out_data.new_vel_y);
          compare_field("new_vel_z", e.new_vel_z, out_data.new_vel_z);
          compare_field("saturated", 32'(e.saturated), 32'(out_data.saturated));
        end
      end
      if (start && !busy) expected_words.push_back(integrate(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_STEP_DT:   step_dt = cfg_data;
          REG_BOX_MIN_X: wall_lo[0] = longint'($signed(cfg_data));
          REG_BOX_MIN_Y: wall_lo[1] = longint'($signed(cfg_data));
          REG_BOX_MIN_Z: wall_lo[2] = longint'($signed(cfg_data));
          REG_BOX_MAX_X: wall_hi[0] = longint'($signed(cfg_data));
          REG_BOX_MAX_Y: wall_hi[1] = longint'($signed(cfg_data));
          REG_BOX_MAX_Z: wall_hi[2] = longint'($signed(cfg_data));
          default: ;
        endcase
      end
    end
  end

endmodule

// File: dv/tb_top.sv
// Testbench top for the particle integrator: stimulus, config phases and verdict.
`timescale 1ns / 1ps
module tb_top;
  import pir_pkg::*;

  // Index past the register list; the block must drop writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  // Idle margin after the last result when draining.
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] ONE      = 32'h0001_0000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  pir_in_t              in_data = '0;
  logic                 done;
  pir_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;
  int                   fails;
  int                   pending;
  int                   cycles = 0;
  bit                   steady;  // no gaps while set

  always #6 clk = ~clk;

  particle_integrate_reflect dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_data(in_data),
    .done(done), .out_data(out_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pir_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_data(in_data),
    .done(done), .out_data(out_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .fails(fails), .pending(pending)
  );

  // Bail out if the pipeline hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly no gap, some short gaps, a few long ones, none at all during steady stretches.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Field value: small numbers near the box dominate, plus extremes and full range.
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    if (r < 55) return MOST_NEG;
    if (r < 65) return MOST_POS;
    if (r < 70) return 32'h0;
    if (r < 75) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_mass();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'h0;
    if (r < 12) return 32'h1;
    if (r < 60) return $urandom_range(32'h0000_4000, 32'h0004_0000);
    return $urandom;
  endfunction

  // Hold start high until the word is taken, then idle for a random gap.
  task automatic send_word(pir_in_t w);
    int g;
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      in_data <= {$urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom};
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_fields(logic [31:0] p, logic [31:0] v, logic [31:0] f,
                             logic [31:0] m);
    pir_in_t w;
    w = '{p, p, p, v, v, v, f, f, f, m};
    send_word(w);
  endtask

  task automatic send_random();
    pir_in_t w;
    w = '{pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
          pick_word(), pick_word(), pick_word(), pick_word(), pick_mass()};
    send_word(w);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Lower start, let every result come back, then let the pipe go quiet.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_box(logic [31:0] dt, logic [31:0] lo, logic [31:0] hi);
    write_reg(REG_STEP_DT, dt);
    write_reg(REG_BOX_MIN_X, lo);
    write_reg(REG_BOX_MIN_Y, lo);
    write_reg(REG_BOX_MIN_Z, lo);
    write_reg(REG_BOX_MAX_X, hi);
    write_reg(REG_BOX_MAX_Y, hi);
    write_reg(REG_BOX_MAX_Z, hi);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) steady = ($urandom_range(0, 3) == 0);
      send_random();
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset register values.
    steady = 1'b0;
    send_fields(32'h0, 32'h0, 32'h0, ONE);
    send_fields(32'h0000_8000, 32'h0, 32'h0, ONE);
    send_fields(MOST_POS, MOST_POS, MOST_POS, 32'h1);
    send_fields(MOST_NEG, MOST_NEG, MOST_NEG, 32'h1);
    send_fields(32'h0000_8000, 32'h0, ONE, 32'h0);       // zero mass, positive force
    send_fields(32'h0000_8000, 32'h0, 32'hFFFF_0000, 32'h0); // zero mass, negative force
    send_fields(32'h0000_8000, ONE, 32'h0, 32'h0);       // zero mass, zero force
    send_fields(32'hFFFF_0000, MOST_NEG, 32'h0, ONE);    // below min, negate most negative
    send_fields(32'h0002_0000, MOST_NEG, 32'h0, ONE);    // above max with most negative vel
    send_fields(32'h0001_8000, 32'h0, 32'h0, ONE);       // above max
    send_fields(32'hFFFF_8000, 32'h0, 32'h0, ONE);       // below min
    send_fields(32'h0, 32'h0, MOST_POS, 32'hFFFF_FFFF);
    send_fields(32'h0, 32'h0, MOST_NEG, 32'hFFFF_FFFF);
    send_fields(32'h0000_8000, 32'h0064_0000, 32'h0, ONE);
    drain();

    // Register write to an unmapped index, then a box with min above max.
    write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
    load_box(ONE, 32'h0002_0000, 32'hFFFF_0000);
    send_fields(32'h0000_8000, 32'h0, 32'h0, ONE);
    send_fields(32'h0003_0000, 32'h0, 32'h0, ONE);
    send_fields(32'hFFFE_0000, 32'h0, 32'h0, ONE);
    drain();

    // Extreme walls and steps.
    load_box(32'hFFFF_FFFF, MOST_NEG, MOST_POS);
    send_fields(MOST_POS, MOST_POS, MOST_POS, 32'h1);
    send_fields(MOST_NEG, MOST_NEG, MOST_NEG, 32'h1);
    send_fields(32'h0, 32'h1, 32'h0, ONE);
    drain();
    load_box(32'h0, MOST_POS, MOST_NEG);
    send_fields(MOST_POS, 32'h0, 32'h0, ONE);
    send_fields(MOST_NEG, MOST_NEG, 32'h0, ONE);
    drain();

    // Random phases over a spread of settings.
    load_box(STEP_DT_RST, BOX_MIN_RST, BOX_MAX_RST);
    random_phase(180);
    load_box(ONE, 32'hFFFE_0000, 32'h0002_0000);
    random_phase(180);
    load_box(32'hFFFF_FFFF, MOST_NEG, MOST_POS);
    random_phase(160);
    load_box(32'h0, 32'h0, 32'h0);
    random_phase(140);
    load_box(32'h0000_0100, 32'h0001_0000, 32'hFFFF_0000);
    random_phase(160);
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_STEP_DT, (k % 2) ? $urandom : $urandom_range(0, 32'h0002_0000));
      write_reg(REG_BOX_MIN_X, pick_word());
      write_reg(REG_BOX_MIN_Y, pick_word());
      write_reg(REG_BOX_MIN_Z, pick_word());
      write_reg(REG_BOX_MAX_X, pick_word());
      write_reg(REG_BOX_MAX_Y, pick_word());
      write_reg(REG_BOX_MAX_Z, pick_word());
      random_phase(150);
    end

    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pir_pkg.sv
rtl/core/pir_div.sv
rtl/core/pir_lane.sv
rtl/core/particle_integrate_reflect.sv
dv/pir_checker.sv
dv/tb_top.sv
